/* rtl/ntfsrl_pkg.sv */
`default_nettype none

package ntfsrl_pkg;

    // bits in a valid logical cluster number
    localparam int CLUSTER_BITS = 48;

    // widths fixed by the stream fields
    localparam int VCN_W     = 48;
    localparam int ACC_W     = 64;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 96;

    // highest legal running lcn and highest legal reported lcn
    localparam logic [ACC_W-1:0] MASK48 = {{(ACC_W-VCN_W){1'b0}}, {VCN_W{1'b1}}};
    localparam logic [ACC_W-1:0] LCN_LIMIT = (CLUSTER_BITS >= ACC_W) ? {ACC_W{1'b1}}
                                           : ((ACC_W'(1) << CLUSTER_BITS) - ACC_W'(1));
    localparam logic [ACC_W-1:0] LCN_MAX = (LCN_LIMIT < MASK48) ? LCN_LIMIT : MASK48;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_SPARSE    = 2'd1,
        ST_UNMAPPED  = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef struct packed {
        logic [VCN_W-1:0] end_vcn;
        logic [VCN_W-1:0] start_vcn;
        logic [VCN_W-1:0] target_vcn;
        logic             first_byte;
        logic [7:0]       run_byte;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [VCN_W-1:0] lcn;
        logic [VCN_W-1:0] run_clusters;
    } result_t;

endpackage

`default_nettype wire

/* rtl/ntfsrl_in_stage.sv */
`default_nettype none

module ntfsrl_in_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // run_byte [7:0], target_vcn [55:8], start_vcn [103:56], end_vcn [151:104]
    input  wire logic [ntfsrl_pkg::S_TDATA_W-1:0] s_tdata,
    // first_byte [0]
    input  wire logic                            s_tuser,
    input  wire logic                            item_take,
    output logic                                 item_valid,
    output ntfsrl_pkg::in_item_t                 item
);
    import ntfsrl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     s_accept;

    // free slot or slot draining this cycle
    assign s_tready   = !valid_reg || item_take;
    assign s_accept   = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_accept) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // unpack request fields
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.run_byte   <= s_tdata[7:0];
            item_reg.target_vcn <= s_tdata[55:8];
            item_reg.start_vcn  <= s_tdata[103:56];
            item_reg.end_vcn    <= s_tdata[151:104];
            item_reg.first_byte <= s_tuser;
        end
    end

endmodule

`default_nettype wire

/* rtl/ntfsrl_decode.sv */
`default_nettype none

module ntfsrl_decode (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire ntfsrl_pkg::in_item_t item,
    output logic                      res_valid,
    output ntfsrl_pkg::result_t       res
);
    import ntfsrl_pkg::*;

    // run list state
    phase_t             phase_reg, phase_next;
    logic [3:0]         len_sz_reg, len_sz_next;
    logic [3:0]         off_sz_reg, off_sz_next;
    logic [3:0]         idx_reg, idx_next;
    logic [ACC_W-1:0]   len_acc_reg, len_acc_next;
    logic [ACC_W-1:0]   off_acc_reg, off_acc_next;
    logic [ACC_W-1:0]   lcn_reg, lcn_next;
    logic [VCN_W-1:0]   rel_reg, rel_next;
    logic               done_reg, done_next;

    // state as seen by this request (a first byte restarts the list)
    phase_t             cur_phase;
    logic [3:0]         cur_len_sz;
    logic [3:0]         cur_off_sz;
    logic [3:0]         cur_idx;
    logic [ACC_W-1:0]   cur_len_acc;
    logic [ACC_W-1:0]   cur_off_acc;
    logic [ACC_W-1:0]   cur_lcn;
    logic [VCN_W-1:0]   cur_rel;
    logic               cur_done;
    logic               out_of_range;

    // field byte insertion
    logic [7:0]         b;
    logic [5:0]         byte_sh;
    logic [ACC_W-1:0]   len_ins;
    logic [ACC_W-1:0]   off_ins;
    logic [3:0]         idx_inc;

    // end-of-run evaluation
    logic               fin;
    logic               sparse;
    logic [ACC_W-1:0]   fin_len;
    logic [5:0]         sign_idx;
    logic [ACC_W-1:0]   hi_mask;
    logic [ACC_W-1:0]   off_ext;
    logic [ACC_W-1:0]   new_lcn;
    logic               lcn_bad;
    logic               hit;
    logic [ACC_W-1:0]   tgt_lcn;
    logic               tgt_bad;
    logic [VCN_W-1:0]   cnt;

    // restart view on a first byte
    always_comb begin
        cur_phase    = item.first_byte ? PH_HEADER : phase_reg;
        cur_len_sz   = item.first_byte ? 4'd0 : len_sz_reg;
        cur_off_sz   = item.first_byte ? 4'd0 : off_sz_reg;
        cur_idx      = item.first_byte ? 4'd0 : idx_reg;
        cur_len_acc  = item.first_byte ? '0 : len_acc_reg;
        cur_off_acc  = item.first_byte ? '0 : off_acc_reg;
        cur_lcn      = item.first_byte ? '0 : lcn_reg;
        cur_rel      = item.first_byte ? (item.target_vcn - item.start_vcn) : rel_reg;
        cur_done     = item.first_byte ? 1'b0 : done_reg;
        out_of_range = item.first_byte && ((item.target_vcn < item.start_vcn) ||
                                           (item.target_vcn > item.end_vcn));
    end

    // little endian byte placement into the field accumulators
    assign b       = item.run_byte;
    assign byte_sh = {cur_idx[2:0], 3'b000};
    assign len_ins = cur_len_acc | ({{(ACC_W-8){1'b0}}, b} << byte_sh);
    assign off_ins = cur_off_acc | ({{(ACC_W-8){1'b0}}, b} << byte_sh);
    assign idx_inc = cur_idx + 4'd1;

    // offset sign extension, new running lcn and target lookup
    assign sparse   = (cur_off_sz == 4'd0);
    assign fin_len  = (cur_phase == PH_LENGTH) ? len_ins : cur_len_acc;
    assign sign_idx = {cur_off_sz[2:0], 3'b000} - 6'd1;
    assign hi_mask  = {ACC_W{1'b1}} << {cur_off_sz[2:0], 3'b000};
    assign off_ext  = (cur_off_sz < 4'd8 && off_ins[sign_idx]) ? (off_ins | hi_mask) : off_ins;
    assign new_lcn  = cur_lcn + off_ext;
    assign lcn_bad  = new_lcn[ACC_W-1] || (new_lcn > LCN_LIMIT);
    assign hit      = {{(ACC_W-VCN_W){1'b0}}, cur_rel} < fin_len;
    assign tgt_lcn  = cur_lcn + off_ext + {{(ACC_W-VCN_W){1'b0}}, cur_rel};
    assign tgt_bad  = tgt_lcn > LCN_MAX;
    assign cnt      = (|fin_len[ACC_W-1:VCN_W]) ? {VCN_W{1'b1}} : fin_len[VCN_W-1:0];

    // next state and result
    always_comb begin
        phase_next   = phase_reg;
        len_sz_next  = len_sz_reg;
        off_sz_next  = off_sz_reg;
        idx_next     = idx_reg;
        len_acc_next = len_acc_reg;
        off_acc_next = off_acc_reg;
        lcn_next     = lcn_reg;
        rel_next     = rel_reg;
        done_next    = done_reg;
        fin          = 1'b0;
        res_valid    = 1'b0;
        res.status   = ST_UNMAPPED;
        res.lcn      = '0;
        res.run_clusters = '0;

        if (step) begin
            phase_next   = cur_phase;
            len_sz_next  = cur_len_sz;
            off_sz_next  = cur_off_sz;
            idx_next     = cur_idx;
            len_acc_next = cur_len_acc;
            off_acc_next = cur_off_acc;
            lcn_next     = cur_lcn;
            rel_next     = cur_rel;
            done_next    = cur_done;

            if (out_of_range) begin
                res_valid  = 1'b1;
                res.status = ST_UNMAPPED;
            end else if (!cur_done) begin
                case (cur_phase)
                    PH_LENGTH: begin
                        len_acc_next = len_ins;
                        idx_next     = idx_inc;
                        if (idx_inc >= cur_len_sz) begin
                            idx_next = 4'd0;
                            if (sparse) begin
                                fin = 1'b1;
                            end else begin
                                phase_next = PH_OFFSET;
                            end
                        end
                    end
                    PH_OFFSET: begin
                        off_acc_next = off_ins;
                        idx_next     = idx_inc;
                        if (idx_inc >= cur_off_sz) begin
                            idx_next = 4'd0;
                            fin      = 1'b1;
                        end
                    end
                    default: begin
                        // run header
                        if (b == 8'd0) begin
                            res_valid  = 1'b1;
                            res.status = ST_UNMAPPED;
                        end else begin
                            len_sz_next = b[3:0];
                            off_sz_next = b[7:4];
                            if (b[3:0] > 4'd8 || b[7:4] > 4'd8) begin
                                res_valid  = 1'b1;
                                res.status = ST_MALFORMED;
                            end else begin
                                idx_next     = 4'd0;
                                len_acc_next = '0;
                                off_acc_next = '0;
                                phase_next   = (b[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
                            end
                        end
                    end
                endcase

                // end of a run
                if (fin) begin
                    phase_next = PH_HEADER;
                    if (!sparse) begin
                        lcn_next = new_lcn;
                    end
                    if (!sparse && lcn_bad) begin
                        res_valid  = 1'b1;
                        res.status = ST_MALFORMED;
                    end else if (hit) begin
                        res_valid = 1'b1;
                        if (sparse) begin
                            res.status       = ST_SPARSE;
                            res.run_clusters = cnt;
                        end else if (tgt_bad) begin
                            res.status = ST_MALFORMED;
                        end else begin
                            res.status       = ST_MAPPED;
                            res.lcn          = tgt_lcn[VCN_W-1:0];
                            res.run_clusters = cnt;
                        end
                    end else begin
                        rel_next = cur_rel - fin_len[VCN_W-1:0];
                    end
                end
            end

            // any result closes the list
            if (res_valid) begin
                done_next  = 1'b1;
                phase_next = PH_HEADER;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            len_sz_reg <= 4'd0;
            off_sz_reg <= 4'd0;
            idx_reg    <= 4'd0;
            done_reg   <= 1'b1;
        end else begin
            phase_reg  <= phase_next;
            len_sz_reg <= len_sz_next;
            off_sz_reg <= off_sz_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
        end
    end

    // accumulators and cluster tracking
    always_ff @(posedge aclk) begin
        len_acc_reg <= len_acc_next;
        off_acc_reg <= off_acc_next;
        lcn_reg     <= lcn_next;
        rel_reg     <= rel_next;
    end

    // a closed list stays quiet until the next first byte
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done_reg && !item.first_byte) |-> !res_valid)
        else $error("result produced while no list open");

    // only a mapped result carries an lcn
    a_lcn_only_mapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_MAPPED) |-> (res.lcn == '0))
        else $error("lcn set on a result that is not mapped");

    // failures carry no run size
    a_fail_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == ST_UNMAPPED || res.status == ST_MALFORMED))
        |-> (res.run_clusters == '0))
        else $error("run size set on a failed lookup");

    // field byte counter stays inside the length field
    a_len_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENGTH) |-> (idx_reg < len_sz_reg))
        else $error("length field byte index out of range");

endmodule

`default_nettype wire

/* rtl/ntfsrl_out_stage.sv */
`default_nettype none

module ntfsrl_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire ntfsrl_pkg::result_t             res,
    output logic                                 out_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // lcn [47:0], run_clusters [95:48]
    output logic [ntfsrl_pkg::M_TDATA_W-1:0]     m_tdata,
    // status [1:0]
    output logic [1:0]                           m_tuser
);
    import ntfsrl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // slot free now or emptied this cycle
    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {res_reg.run_clusters, res_reg.lcn};
    assign m_tuser   = res_reg.status;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* rtl/ntfs_run_list_vcn_mapper.sv */
// channel | dir | tdata fields (low bit up)                            | tuser
// s_      | in  | run_byte, target_vcn, start_vcn, end_vcn (152 bits)  | first_byte
// m_      | out | lcn, run_clusters (96 bits)                          | status
//
// one run list byte per cycle while the result slot is free or draining;
// a byte waits in the input register and its result, if any, appears on m_
// the whole per-byte step (field insert, offset add, run lookup) is one
// combinational stage between the input register and the result register
// aresetn low clears both stages and closes the list until a first byte
// a stalled result holds the decode stage; one more request waits in the
// input register, then s_tready drops
`default_nettype none

module ntfs_run_list_vcn_mapper (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // run_byte [7:0], target_vcn [55:8], start_vcn [103:56], end_vcn [151:104]
    input  wire logic [ntfsrl_pkg::S_TDATA_W-1:0] s_tdata,
    // first_byte [0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // lcn [47:0], run_clusters [95:48]
    output logic [ntfsrl_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [1:0]
    output logic [1:0]                            m_tuser
);
    import ntfsrl_pkg::*;

    in_item_t item;
    logic     item_valid;
    logic     out_ready;
    logic     step;
    logic     res_valid;
    result_t  res;

    // a byte is decoded when the result slot can take its outcome
    assign step = item_valid && out_ready;

    ntfsrl_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_take  (step),
        .item_valid (item_valid),
        .item       (item)
    );

    ntfsrl_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ntfsrl_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ntfsrl_pkg::*;

    localparam logic [47:0] VCN_ALL = 48'hFFFF_FFFF_FFFF;

    // tracks the open run list and holds the lookups still owed by the block
    class run_map_scoreboard;
        localparam logic [63:0] LCN_CEIL = (CLUSTER_BITS >= 64) ? {64{1'b1}}
                                         : ((64'd1 << CLUSTER_BITS) - 64'd1);
        localparam logic [63:0] VCN_MASK = 64'h0000_FFFF_FFFF_FFFF;

        result_t     lookup_q[$];
        int          mismatches;
        phase_t      phase;
        logic [3:0]  len_size;
        logic [3:0]  off_size;
        logic [3:0]  byte_idx;
        logic [63:0] len_acc;
        logic [63:0] off_acc;
        logic [63:0] lcn_acc;
        logic [47:0] run_vcn;
        logic [47:0] wanted_vcn;
        bit          list_closed;

        function new();
            mismatches  = 0;
            phase       = PH_HEADER;
            len_size    = '0;
            off_size    = '0;
            byte_idx    = '0;
            len_acc     = '0;
            off_acc     = '0;
            lcn_acc     = '0;
            run_vcn     = '0;
            wanted_vcn  = '0;
            list_closed = 1'b1;
        endfunction

        function int pending();
            return lookup_q.size();
        endfunction

        function void close_list(status_t st, logic [63:0] lcn, logic [63:0] cnt);
            result_t r;
            r.status       = st;
            r.lcn          = lcn[47:0];
            r.run_clusters = cnt[47:0];
            lookup_q.push_back(r);
            list_closed = 1'b1;
            phase       = PH_HEADER;
        endfunction

        // a run is complete: move the lcn, then see whether it holds the target
        function void end_run();
            logic [63:0] off;
            logic [63:0] rel;
            logic [63:0] lcn;
            logic [63:0] clusters;
            if (off_size != 0) begin
                off = off_acc;
                if (off_size < 8 && off_acc[off_size*8-1])
                    off = off | ({64{1'b1}} << (off_size*8));
                lcn_acc = lcn_acc + off;
                if (lcn_acc[63] || lcn_acc > LCN_CEIL) begin
                    close_list(ST_MALFORMED, '0, '0);
                    return;
                end
            end
            phase    = PH_HEADER;
            rel      = {16'd0, wanted_vcn} - {16'd0, run_vcn};
            clusters = (len_acc > VCN_MASK) ? VCN_MASK : len_acc;
            if (wanted_vcn >= run_vcn && rel < len_acc) begin
                if (off_size == 0) begin
                    close_list(ST_SPARSE, '0, clusters);
                end else begin
                    lcn = lcn_acc + rel;
                    if (lcn < lcn_acc || lcn > LCN_CEIL || lcn > VCN_MASK)
                        close_list(ST_MALFORMED, '0, '0);
                    else
                        close_list(ST_MAPPED, lcn, clusters);
                end
            end else begin
                run_vcn = run_vcn + len_acc[47:0];
            end
        endfunction

        // returns 1 when the byte is consumed, 0 when the block ignores it
        function bit note_request(logic [7:0] rb, bit first_flag, logic [47:0] tgt,
                                  logic [47:0] st, logic [47:0] en);
            bit used;
            used = first_flag || !list_closed;
            if (first_flag) begin
                wanted_vcn  = tgt;
                run_vcn     = st;
                lcn_acc     = '0;
                phase       = PH_HEADER;
                byte_idx    = '0;
                len_acc     = '0;
                off_acc     = '0;
                len_size    = '0;
                off_size    = '0;
                list_closed = 1'b0;
                if (tgt < st || tgt > en) begin
                    close_list(ST_UNMAPPED, '0, '0);
                    return used;
                end
            end
            if (list_closed)
                return used;
            case (phase)
                PH_LENGTH: begin
                    len_acc  = len_acc | (64'(rb) << (byte_idx[2:0]*8));
                    byte_idx = byte_idx + 4'd1;
                    if (byte_idx >= len_size) begin
                        byte_idx = '0;
                        if (off_size == 0)
                            end_run();
                        else
                            phase = PH_OFFSET;
                    end
                end
                PH_OFFSET: begin
                    off_acc  = off_acc | (64'(rb) << (byte_idx[2:0]*8));
                    byte_idx = byte_idx + 4'd1;
                    if (byte_idx >= off_size) begin
                        byte_idx = '0;
                        end_run();
                    end
                end
                default: begin
                    // run header; a zero byte ends the list
                    if (rb == 8'h00) begin
                        close_list(ST_UNMAPPED, '0, '0);
                    end else begin
                        len_size = rb[3:0];
                        off_size = rb[7:4];
                        if (len_size > 8 || off_size > 8) begin
                            close_list(ST_MALFORMED, '0, '0);
                        end else begin
                            byte_idx = '0;
                            len_acc  = '0;
                            off_acc  = '0;
                            phase    = (len_size != 0) ? PH_LENGTH : PH_OFFSET;
                        end
                    end
                end
            endcase
            return used;
        endfunction

        function void check_result(status_t st, logic [47:0] lcn, logic [47:0] cnt);
            result_t want;
            if (lookup_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d lcn %h clusters %h",
                             st, lcn, cnt);
                return;
            end
            want = lookup_q.pop_front();
            if (want.status !== st || want.lcn !== lcn || want.run_clusters !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("lookup differs: status %0d/%0d lcn %h/%h clusters %h/%h",
                             want.status, st, want.lcn, lcn, want.run_clusters, cnt);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    run_map_scoreboard sb = new();
    logic [7:0]        list_bytes[$];
    int                sent_items = 0;
    bit                src_idle   = 1'b1;
    logic              sink_idle  = 1'b1;
    logic              hold_sink  = 1'b0;
    int                sink_wait  = 0;

    ntfs_run_list_vcn_mapper u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result receiver: random stall per result, long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                hold_sink <= 1'b0;
                sink_wait = 300;
            end else if (m_tvalid && m_tready) begin
                sink_wait = sink_idle ? $urandom_range(0, 7) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(status_t'(m_tuser), m_tdata[47:0], m_tdata[95:48]);
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] random_vcn();
        logic [63:0] w;
        w = random_word();
        return w[47:0];
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input logic [7:0] rb, input bit first_flag,
                                input logic [47:0] tgt, input logic [47:0] st,
                                input logic [47:0] en);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {en, st, tgt, rb};
        s_tuser  <= first_flag;
        do @(posedge aclk); while (!s_tready);
        void'(sb.note_request(rb, first_flag, tgt, st, en));
        sent_items++;
    endtask

    // list_bytes in order; the vcn fields ride only on the first byte
    task automatic send_list(input logic [47:0] tgt, input logic [47:0] st,
                             input logic [47:0] en);
        foreach (list_bytes[i]) begin
            if (i == 0)
                send_request(list_bytes[i], 1'b1, tgt, st, en);
            else
                send_request(list_bytes[i], 1'b0, random_vcn(), random_vcn(), random_vcn());
        end
    endtask

    // stop offering until every lookup has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // well formed mapping pairs list with a target mostly inside it
    task automatic build_run_list(output logic [47:0] tgt, output logic [47:0] st,
                                  output logic [47:0] en);
        int          runs;
        int          pick;
        int          len_sz;
        int          off_sz;
        logic [63:0] len;
        logic [63:0] off;
        logic [63:0] mag;
        logic [63:0] cap;
        logic [63:0] total;
        logic [63:0] lcn_sum;
        list_bytes.delete();
        runs    = $urandom_range(1, 6);
        st      = ($urandom_range(0, 3) == 0) ? random_vcn() : 48'($urandom_range(0, 1000));
        total   = '0;
        lcn_sum = '0;
        for (int r = 0; r < runs; r++) begin
            pick   = $urandom_range(0, 15);
            len_sz = (pick == 0) ? 0 : (pick < 12) ? 1 : (pick < 14) ? 2
                   : (pick == 14) ? 3 : $urandom_range(4, 8);
            pick   = $urandom_range(0, 15);
            off_sz = (pick < 3) ? 0 : (pick < 11) ? $urandom_range(1, 2)
                   : (pick < 14) ? 3 : $urandom_range(4, 8);
            if (len_sz == 0 && off_sz == 0)
                len_sz = 1;
            len = random_word();
            if (len_sz < 8)
                len = len & ~({64{1'b1}} << (8*len_sz));
            if (len_sz > 0 && len == 0)
                len = 64'd1;
            off = '0;
            if (off_sz > 0) begin
                cap = (64'd1 << (8*off_sz - 1)) - 64'd1;
                // step back only as far as the lcn allows
                if (lcn_sum != 0 && $urandom_range(0, 2) == 0) begin
                    mag = (lcn_sum < cap) ? lcn_sum : cap;
                    off = -(64'd1 + random_word() % mag);
                end else begin
                    off = random_word() & cap;
                end
            end
            list_bytes.push_back({4'(off_sz), 4'(len_sz)});
            for (int i = 0; i < len_sz; i++) list_bytes.push_back(len[8*i +: 8]);
            for (int i = 0; i < off_sz; i++) list_bytes.push_back(off[8*i +: 8]);
            lcn_sum = lcn_sum + off;
            total   = total + len;
        end
        list_bytes.push_back(8'h00);
        if (total == 0)
            en = st;
        else if (64'(st) + total - 64'd1 > 64'(VCN_ALL))
            en = VCN_ALL;
        else
            en = 48'(64'(st) + total - 64'd1);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            tgt = (total == 0) ? st : 48'(64'(st) + random_word() % total);
        end else if (pick == 7) begin
            // just past the last run: list runs out
            tgt = 48'(64'(st) + total);
            en  = (tgt > en) ? tgt : en;
        end else if (pick == 8) begin
            tgt = (st == 0) ? random_vcn() : 48'(64'(st) - 64'd1 - random_word() % 64'(st));
        end else begin
            tgt = en;
            en  = (tgt == 0) ? '0 : tgt - 48'd1;
        end
    endtask

    // timeout
    initial begin
        #2_000_000;
        $display("ntfs_run_list_vcn_mapper: mismatch");
        $finish;
    end

    // stimulus
    initial begin
        int          pick;
        int          list_no;
        int          rand_goal;
        logic [47:0] tgt;
        logic [47:0] st;
        logic [47:0] en;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle byte before any list is opened
        send_request(8'hFF, 1'b0, VCN_ALL, VCN_ALL, VCN_ALL);
        // target below start, then above end
        list_bytes = '{8'h11};
        send_list(48'd5, 48'd10, 48'd20);
        list_bytes = '{8'h00};
        send_list(VCN_ALL, 48'd0, VCN_ALL - 48'd1);
        // one plain run: 16 clusters at lcn 0x20
        list_bytes = '{8'h11, 8'h10, 8'h20};
        send_list(48'd5, 48'd0, VCN_ALL);
        // list ends before the target
        list_bytes = '{8'h00};
        send_list(48'd0, 48'd0, 48'd0);
        // oversized length field, oversized offset field
        list_bytes = '{8'h19};
        send_list(48'd0, 48'd0, 48'd0);
        list_bytes = '{8'h91};
        send_list(48'd0, 48'd0, 48'd0);
        // sparse run holding the target
        list_bytes = '{8'h01, 8'h08};
        send_list(48'd12, 48'd10, 48'd17);
        // zero length run moves the lcn, then a negative offset
        list_bytes = '{8'h10, 8'h05, 8'h11, 8'h04, 8'hFF};
        send_list(48'd0, 48'd0, 48'd3);
        // lcn goes negative
        list_bytes = '{8'h11, 8'h01, 8'h80};
        send_list(48'd0, 48'd0, 48'd0);
        // eight byte length saturates the cluster count
        list_bytes = '{8'h18, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_list(48'd1000, 48'd0, VCN_ALL);
        wait_for_results();

        // random lists, broken lists and noise
        rand_goal = sent_items + 1350;
        list_no   = 0;
        while (sent_items < rand_goal) begin
            if (list_no % 8 == 0) begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle <= ($urandom_range(0, 3) != 0);
            end
            // receiver holds off while out of range requests keep coming
            if (list_no == 25 || list_no == 140) begin
                hold_sink <= 1'b1;
                repeat (12)
                    send_request(8'($urandom), 1'b1, VCN_ALL, 48'd0, random_vcn() >> 1);
                wait_for_results();
            end
            if (list_no % 40 == 39)
                wait_for_results();
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                build_run_list(tgt, st, en);
                send_list(tgt, st, en);
            end else if (pick < 17) begin
                build_run_list(tgt, st, en);
                if ($urandom_range(0, 1) == 0)
                    list_bytes[$urandom_range(1, list_bytes.size() - 1)] = 8'($urandom);
                else
                    repeat ($urandom_range(1, list_bytes.size() - 1))
                        void'(list_bytes.pop_back());
                send_list(tgt, st, en);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(8'($urandom), ($urandom_range(0, 3) == 0),
                                 random_vcn(), random_vcn(), random_vcn());
            end
            list_no++;
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ntfs_run_list_vcn_mapper: match");
        else
            $display("ntfs_run_list_vcn_mapper: mismatch");
        $finish;
    end

endmodule
